// File: rtl/dpq_pkg.sv
// shared types, constants and register codes of the dead-band piecewise quantizer
package dpq_pkg;

	// default sample width, signed Q4.12
	localparam int SAMPLE_BITS_DEF = 16;

	// configuration port
	localparam int CFG_IDX_W = 3;
	localparam int CFG_W     = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DEADBAND    = 3'd0,
		CFG_WINDOW_LOW  = 3'd1,
		CFG_WINDOW_HIGH = 3'd2,
		CFG_FINE_SHARE  = 3'd3,
		CFG_CODE_BITS   = 3'd4
	} cfg_idx_t;

	localparam logic [15:0] DEADBAND_RST    = 16'd410;
	localparam logic [15:0] WINDOW_LOW_RST  = 16'hF000;
	localparam logic [15:0] WINDOW_HIGH_RST = 16'h1000;
	localparam logic [15:0] FINE_SHARE_RST  = 16'h8000;
	localparam logic [3:0]  CODE_BITS_RST   = 4'd4;

	// output code
	localparam int CODE_W   = 8;
	localparam int CODE_MAX = 8;

	// fixed-point constants: 3.0 in Q4.12, span 6.0, 1.0 in Q0.16
	localparam int THREE_Q   = 12288;
	localparam int SPAN_Q    = 2 * THREE_Q;
	localparam int ONE_SHARE = 65536;

	// coarse denominator is 2*ONE_SHARE*SPAN_Q = 3 * 2^30
	localparam int COARSE_SHIFT = 30;
	localparam int COARSE_ODD   = 3;
	// fine denominator is ONE_SHARE * (window_high - window_low)
	localparam int FINE_SHIFT   = 16;

	// coarse numerator at or above twice the denominator always saturates
	localparam longint SAT_LIM = 64'd6442450944;

	// datapath widths
	localparam int BASE_W = 33;
	localparam int PROD_W = BASE_W + CODE_W;

	// serial divider
	localparam int DIV_NW = 24;
	localparam int DIV_DW = 16;

	typedef struct packed {
		logic gate;
		logic mul_a;
		logic add_c;
		logic mul_b;
		logic div_start;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic emit;
		logic div_done;
		logic out_free;
	} stat_t;

endpackage

// File: rtl/dpq_if.sv
// valid/ready channel interfaces for samples in and codes out
interface dpq_in_if #(
	parameter int SAMPLE_BITS = dpq_pkg::SAMPLE_BITS_DEF
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample;
	logic                          start_req;

	modport source (output valid, output sample, output start_req, input ready);
	modport sink   (input valid, input sample, input start_req, output ready);
endinterface

interface dpq_out_if;
	import dpq_pkg::*;

	logic              valid;
	logic              ready;
	logic [CODE_W-1:0] code;

	modport source (output valid, output code, input ready);
	modport sink   (input valid, input code, output ready);
endinterface

// File: rtl/deadband_piecewise_quantizer.sv
// top level of the dead-band piecewise quantizer
// A signed Q4.12 sample is transferred in, checked against the last emitted
// sample and, when start_req is set, no reference exists yet, or the distance
// reaches deadband, mapped to a code of code_bits bits: linearly over the fine
// window onto [0, fine_share], and onto two coarse segments outside it, over
// the fixed span [-3, 3], then scaled by 2^code_bits - 1, truncated and
// saturated. A sample inside the dead band gives no code and frees the input
// again after the gate state. An emitted sample keeps the input closed through
// one gate step, two multiply steps with an add between them, one step to
// start the divider, 24 divide steps at one quotient bit per cycle and one
// step to flag the quotient. The code is loaded into the output register in
// the cycle after the input reopens, when the next sample can first be taken.
// The output register lets the next sample in while a code waits to be
// taken; only when that code is still held at the end of the next divide does
// the block wait. The user must write cfg_we/cfg_index/cfg_data configuration
// only while the block is idle; the block itself does not enforce this.
module deadband_piecewise_quantizer #(
	parameter int SAMPLE_BITS = dpq_pkg::SAMPLE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	dpq_in_if.sink                        samples,
	dpq_out_if.source                     codes,
	input  logic                          cfg_we,
	input  logic [dpq_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [dpq_pkg::CFG_W-1:0]     cfg_data
);
	import dpq_pkg::*;

	cmd_t              cmd;
	stat_t             stat;
	logic              in_ready;
	logic              take;
	logic              emit;
	logic              out_free;
	logic              div_done;
	logic [DIV_NW-1:0] dividend;
	logic [DIV_DW-1:0] divisor;
	logic [DIV_NW-1:0] quotient;

	// input transfer
	assign samples.ready = in_ready;
	assign take          = samples.valid && in_ready;

	// status back to the sequencer
	assign stat.emit     = emit;
	assign stat.div_done = div_done;
	assign stat.out_free = out_free;

	dpq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (samples.valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	dpq_dp #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.take      (take),
		.sample    (samples.sample),
		.start_req (samples.start_req),
		.cmd       (cmd),
		.emit      (emit),
		.out_free  (out_free),
		.dividend  (dividend),
		.divisor   (divisor),
		.quotient  (quotient),
		.out_ready (codes.ready),
		.out_valid (codes.valid),
		.code      (codes.code)
	);

	// shared divider for both segment kinds
	dpq_div #(
		.NW (DIV_NW),
		.DW (DIV_DW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (dividend),
		.divisor  (divisor),
		.quotient (quotient),
		.done     (div_done)
	);
endmodule

// File: rtl/dpq_div.sv
// restoring bit-serial unsigned divider, one quotient bit per cycle
module dpq_div #(
	parameter int NW = dpq_pkg::DIV_NW,
	parameter int DW = dpq_pkg::DIV_DW
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] dividend,
	input  logic [DW-1:0] divisor,
	output logic [NW-1:0] quotient,
	output logic          done
);
	localparam int CNTW = $clog2(NW + 1);

	logic [DW-1:0]   rem_q;
	logic [NW-1:0]   quo_q;
	logic [DW-1:0]   dvs_q;
	logic [CNTW-1:0] cnt_q;
	logic            busy_q;
	logic            done_q;

	logic [DW:0]     shift_rem;
	logic [DW:0]     trial;
	logic            fits;

	assign shift_rem = {rem_q, quo_q[NW-1]};
	assign fits      = shift_rem >= {1'b0, dvs_q};
	assign trial     = shift_rem - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNTW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNTW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? trial[DW-1:0] : shift_rem[DW-1:0];
			quo_q <= {quo_q[NW-2:0], fits};
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;
endmodule

// File: rtl/dpq_ctrl.sv
// sequencing state machine: gate, two multiply steps with an add between them, divide, output load
module dpq_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  dpq_pkg::stat_t stat,
	output dpq_pkg::cmd_t  cmd
);
	import dpq_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_GATE,
		ST_MULA,
		ST_ADDC,
		ST_MULB,
		ST_DIVW,
		ST_DONE
	} state_t;

	state_t state_q;
	logic   in_ready_q;
	cmd_t   cmd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			in_ready_q <= 1'b1;
			cmd_q      <= '0;
		end else begin
			cmd_q <= '0;
			case (state_q)
				ST_IDLE: begin
					if (in_valid && in_ready_q) begin
						state_q    <= ST_GATE;
						in_ready_q <= 1'b0;
						cmd_q.gate <= 1'b1;
					end
				end
				ST_GATE: begin
					if (stat.emit) begin
						state_q     <= ST_MULA;
						cmd_q.mul_a <= 1'b1;
					end else begin
						state_q    <= ST_IDLE;
						in_ready_q <= 1'b1;
					end
				end
				ST_MULA: begin
					state_q     <= ST_ADDC;
					cmd_q.add_c <= 1'b1;
				end
				ST_ADDC: begin
					state_q     <= ST_MULB;
					cmd_q.mul_b <= 1'b1;
				end
				ST_MULB: begin
					state_q         <= ST_DIVW;
					cmd_q.div_start <= 1'b1;
				end
				ST_DIVW: begin
					if (stat.div_done) begin
						if (stat.out_free) begin
							state_q        <= ST_IDLE;
							in_ready_q     <= 1'b1;
							cmd_q.load_out <= 1'b1;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_DONE: begin
					if (stat.out_free) begin
						state_q        <= ST_IDLE;
						in_ready_q     <= 1'b1;
						cmd_q.load_out <= 1'b1;
					end
				end
				default: begin
					state_q    <= ST_IDLE;
					in_ready_q <= 1'b1;
				end
			endcase
		end
	end

	assign in_ready = in_ready_q;
	assign cmd      = cmd_q;
endmodule

// File: rtl/dpq_dp.sv
// datapath: config registers, dead-band gate, segment mapping, output register
module dpq_dp #(
	parameter int SAMPLE_BITS = dpq_pkg::SAMPLE_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [dpq_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [dpq_pkg::CFG_W-1:0]         cfg_data,
	input  logic                              take,
	input  logic signed [SAMPLE_BITS-1:0]     sample,
	input  logic                              start_req,
	input  dpq_pkg::cmd_t                     cmd,
	output logic                              emit,
	output logic                              out_free,
	output logic [dpq_pkg::DIV_NW-1:0]        dividend,
	output logic [dpq_pkg::DIV_DW-1:0]        divisor,
	input  logic [dpq_pkg::DIV_NW-1:0]        quotient,
	input  logic                              out_ready,
	output logic                              out_valid,
	output logic [dpq_pkg::CODE_W-1:0]        code
);
	import dpq_pkg::*;

	localparam int SW = SAMPLE_BITS;
	localparam int CW = (SW + 1 > CFG_W) ? SW + 1 : CFG_W;
	localparam int EW = ((SW > 16) ? SW : 16) + 1;
	localparam int BW = (SW + 1 > 17) ? SW + 1 : 17;
	localparam int PW = BW + 18;
	localparam int PM = PW - 1;

	// configuration
	logic [15:0]        deadband_q;
	logic signed [15:0] window_low_q;
	logic signed [15:0] window_high_q;
	logic [15:0]        fine_share_q;
	logic [3:0]         code_bits_q;

	// item and reference
	logic signed [SW-1:0] sample_q;
	logic                 start_q;
	logic signed [SW-1:0] ref_q;
	logic                 ref_valid_q;

	// intermediate results
	logic signed [PW-1:0]  p_q;
	logic [BASE_W-1:0]     base_q;
	logic                  zero_q;
	logic                  sat_q;
	logic [PROD_W-1:0]     t_q;
	logic                  out_valid_q;
	logic [CODE_W-1:0]     code_q;

	logic signed [SW:0]    diff;
	logic [SW:0]           absd;
	logic signed [EW-1:0]  s_e;
	logic signed [EW-1:0]  wl_e;
	logic signed [EW-1:0]  wh_e;
	logic signed [EW-1:0]  d_e;
	logic signed [16:0]    span_e;
	logic                  in_win;
	logic                  point;
	logic [16:0]           rest;
	logic signed [BW-1:0]  shifted;
	logic signed [17:0]    opa;
	logic signed [BW-1:0]  opb;
	logic signed [PW-1:0]  prod;
	logic [BASE_W-1:0]     coff;
	logic signed [PW-1:0]  base;
	logic                  base_pos;
	logic [3:0]            bits;
	logic [CODE_W-1:0]     top;
	logic [CODE_W-1:0]     final_code;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deadband_q    <= DEADBAND_RST;
			window_low_q  <= WINDOW_LOW_RST;
			window_high_q <= WINDOW_HIGH_RST;
			fine_share_q  <= FINE_SHARE_RST;
			code_bits_q   <= CODE_BITS_RST;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_DEADBAND:    deadband_q    <= cfg_data;
				CFG_WINDOW_LOW:  window_low_q  <= cfg_data;
				CFG_WINDOW_HIGH: window_high_q <= cfg_data;
				CFG_FINE_SHARE:  fine_share_q  <= cfg_data;
				CFG_CODE_BITS:   code_bits_q   <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// dead-band gate against the last emitted sample
	assign diff = {sample_q[SW-1], sample_q} - {ref_q[SW-1], ref_q};
	assign absd = diff[SW] ? -diff : diff;
	assign emit = start_q || !ref_valid_q || (CW'(absd) >= CW'(deadband_q));

	// window test
	assign s_e    = EW'(sample_q);
	assign wl_e   = EW'(window_low_q);
	assign wh_e   = EW'(window_high_q);
	assign d_e    = s_e - wl_e;
	assign in_win = (s_e >= wl_e) && (s_e <= wh_e);
	assign point  = window_high_q == window_low_q;
	assign span_e = 17'(window_high_q) - 17'(window_low_q);

	// first product: fine_share*(s-wl) or rest*(s+3)
	assign rest    = 17'(ONE_SHARE) - 17'(fine_share_q);
	assign shifted = BW'(sample_q) + BW'(THREE_Q);
	assign opa     = in_win ? signed'({2'b00, fine_share_q}) : signed'({1'b0, rest});
	assign opb     = in_win ? signed'(BW'({1'b0, d_e[15:0]})) : shifted;
	assign prod    = opa * opb;

	// coarse offset: below zero 2*fs*span, else (fs+1)*span
	assign coff = sample_q[SW-1] ? BASE_W'(fine_share_q) * BASE_W'(2 * SPAN_Q)
	                             : (BASE_W'(fine_share_q) + BASE_W'(ONE_SHARE)) * BASE_W'(SPAN_Q);
	assign base     = in_win ? p_q : p_q + signed'(PW'(coff));
	assign base_pos = !base[PW-1] && (base != '0);

	assign bits = (code_bits_q > 4'(CODE_MAX)) ? 4'(CODE_MAX) : code_bits_q;
	assign top  = CODE_W'((9'd1 << bits) - 9'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_q       <= '0;
			ref_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.gate && emit) begin
				ref_q       <= sample_q;
				ref_valid_q <= 1'b1;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			sample_q <= sample;
			start_q  <= start_req;
		end
		if (cmd.mul_a) begin
			p_q <= prod;
		end
		if (cmd.add_c) begin
			base_q <= base[BASE_W-1:0];
			zero_q <= (in_win && point) || !base_pos || (top == '0);
			sat_q  <= !in_win && base_pos && (base[PW-2:0] >= PM'(SAT_LIM));
		end
		if (cmd.mul_b) begin
			t_q <= PROD_W'(base_q) * PROD_W'(top);
		end
		if (cmd.load_out) begin
			code_q <= final_code;
		end
	end

	// divider operands: fine divides by the window span, coarse by three
	assign dividend = in_win ? t_q[FINE_SHIFT+DIV_NW-1:FINE_SHIFT]
	                         : DIV_NW'(t_q[PROD_W-1:COARSE_SHIFT]);
	assign divisor  = in_win ? span_e[DIV_DW-1:0] : DIV_DW'(COARSE_ODD);

	always_comb begin
		if (zero_q) begin
			final_code = '0;
		end else if (sat_q || (quotient > DIV_NW'(top))) begin
			final_code = top;
		end else begin
			final_code = quotient[CODE_W-1:0];
		end
	end

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign code      = code_q;
endmodule
